FILE: design/bnc_pkg.sv
// Package for the bracket nesting checker: default sizes, opener and status codes,
// sequencer states and the character decode functions.
// No dependencies.
package bnc_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  localparam int SCORE_W = 63;
  localparam int DEPTH_FIELD_W = 7;
  localparam int DEPTH_FIELD_MAX = 127;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL = 1'b1;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_CORRUPT = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [2:0] OP_OTHER = 3'd0;
  localparam logic [2:0] OP_PAREN = 3'd1;
  localparam logic [2:0] OP_SQUARE = 3'd2;
  localparam logic [2:0] OP_CURLY = 3'd3;
  localparam logic [2:0] OP_ANGLE = 3'd4;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_LANGLE = 8'h3C;
  localparam logic [7:0] CH_RANGLE = 8'h3E;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UNWIND
  } seq_state_t;

  function automatic logic [2:0] opener_code(input logic [7:0] ch);
    logic [2:0] code;
    unique case (ch)
      CH_LPAREN:  code = OP_PAREN;
      CH_LSQUARE: code = OP_SQUARE;
      CH_LCURLY:  code = OP_CURLY;
      CH_LANGLE:  code = OP_ANGLE;
      default:    code = OP_OTHER;
    endcase
    return code;
  endfunction

  function automatic logic [2:0] closer_code(input logic [7:0] ch);
    logic [2:0] code;
    unique case (ch)
      CH_RPAREN:  code = OP_PAREN;
      CH_RSQUARE: code = OP_SQUARE;
      CH_RCURLY:  code = OP_CURLY;
      CH_RANGLE:  code = OP_ANGLE;
      default:    code = OP_OTHER;
    endcase
    return code;
  endfunction

endpackage

FILE: design/bracket_nesting_checker_unit.sv
// Bracket nesting checker top level: opener stack memory, line flags and the
// sequencer that drives one shared shift-add unit for the completion score.
// Depends on bnc_pkg.
//
//   channel   signals                               direction
//   item      item_valid item_stall kind symbol     in, stall out
//   result    result_valid result_stall status      out, stall in
//             completion_score open_depth
//
// An opener or other character is handled in ST_IDLE; a closing bracket goes
// through ST_CHECK, since the top entry comes from the registered read port of
// the stack memory. An end-of-line beat on a corrupt, overflowed or empty line is
// answered directly, else one stack entry per cycle goes through the shift-add unit.
// Reset clears the depth and flags at once; the stack memory needs no clearing pass.
// A waiting result stalls only the next end-of-line beat.
module bracket_nesting_checker_unit
  import bnc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     kind,
  input  logic [7:0]               symbol,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [1:0]               status,
  output logic [SCORE_W-1:0]       completion_score,
  output logic [DEPTH_FIELD_W-1:0] open_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

  logic [2:0] stack_mem [STACK_DEPTH];

  seq_state_t state, state_next;
  logic [DW-1:0] depth, depth_next;
  logic corrupt, corrupt_next;
  logic overflow, overflow_next;
  logic [2:0] need, need_next;
  logic [DW-1:0] walk, walk_next;
  logic [SCORE_W-1:0] score, score_next;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [2:0] mem_wdata, rd_data;

  logic item_take;
  logic [DW-1:0] depth_m1, walk_m1;
  logic [2:0] close_need;
  logic [SCORE_W+2:0] mac;
  logic [SCORE_W-1:0] mac_sat;

  logic load;
  logic [1:0] load_status;
  logic [SCORE_W-1:0] load_score;
  logic [DEPTH_FIELD_W-1:0] depth_sat;

  assign item_stall = (state != ST_IDLE) || (result_valid && (kind == KIND_EOL));
  assign item_take = item_valid && !item_stall;
  assign depth_m1 = depth - 1'b1;
  assign walk_m1 = walk - 1'b1;
  assign close_need = closer_code(symbol);

  assign mac = {1'b0, score, 2'b00} + {3'b000, score} + (SCORE_W + 3)'(rd_data);
  assign mac_sat = (mac[SCORE_W+2:SCORE_W] != 3'b000) ? SCORE_MAX : mac[SCORE_W-1:0];

  assign depth_sat = (32'(depth) > DEPTH_FIELD_MAX) ? DEPTH_FIELD_W'(DEPTH_FIELD_MAX)
                                                    : DEPTH_FIELD_W'(depth);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= stack_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      depth <= '0;
      corrupt <= 1'b0;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      corrupt <= corrupt_next;
      overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    need <= need_next;
    walk <= walk_next;
    score <= score_next;
  end

  always_comb begin
    state_next = state;
    depth_next = depth;
    corrupt_next = corrupt;
    overflow_next = overflow;
    need_next = need;
    walk_next = walk;
    score_next = score;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = depth[AW-1:0];
    mem_wdata = opener_code(symbol);
    mem_raddr = depth_m1[AW-1:0];
    load = 1'b0;
    load_status = STAT_OK;
    load_score = '0;

    unique case (state)
      ST_IDLE: begin
        if (item_take) begin
          if (kind == KIND_CHAR) begin
            if (!corrupt && !overflow) begin
              if (close_need != OP_OTHER) begin
                if (depth == '0) begin
                  corrupt_next = 1'b1;
                end else begin
                  mem_re = 1'b1;
                  need_next = close_need;
                  state_next = ST_CHECK;
                end
              end else if (depth == DEPTH_FULL) begin
                overflow_next = 1'b1;
              end else begin
                mem_we = 1'b1;
                depth_next = depth + 1'b1;
              end
            end
          end else begin
            if (corrupt || overflow || (depth == '0)) begin
              load = 1'b1;
              load_status = corrupt ? STAT_CORRUPT : (overflow ? STAT_OVERFLOW : STAT_OK);
              depth_next = '0;
              corrupt_next = 1'b0;
              overflow_next = 1'b0;
            end else begin
              mem_re = 1'b1;
              walk_next = depth_m1;
              score_next = '0;
              state_next = ST_UNWIND;
            end
          end
        end
      end
      ST_CHECK: begin
        if (rd_data != need) begin
          corrupt_next = 1'b1;
        end else begin
          depth_next = depth_m1;
        end
        state_next = ST_IDLE;
      end
      ST_UNWIND: begin
        score_next = mac_sat;
        if (walk == '0) begin
          load = 1'b1;
          load_status = STAT_OK;
          load_score = mac_sat;
          depth_next = '0;
          state_next = ST_IDLE;
        end else begin
          mem_re = 1'b1;
          mem_raddr = walk_m1[AW-1:0];
          walk_next = walk_m1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= load_status;
      completion_score <= load_score;
      open_depth <= depth_sat;
    end
  end

endmodule

FILE: design/bnc_checker.sv
// Port-level assertions for the bracket nesting checker and the bind that
// attaches them to the top level. Depends on bnc_pkg.
module bnc_checker
  import bnc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     item_valid,
  input logic                     item_stall,
  input logic                     kind,
  input logic                     result_valid,
  input logic                     result_stall,
  input logic [1:0]               status,
  input logic [SCORE_W-1:0]       completion_score,
  input logic [DEPTH_FIELD_W-1:0] open_depth
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status)
      && $stable(completion_score) && $stable(open_depth))
    else $error("stalled result beat changed");

  a_score_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STAT_OK) |-> completion_score == '0)
    else $error("score not zero on a corrupt or overflowed line");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == STAT_OK) || (status == STAT_CORRUPT)
      || (status == STAT_OVERFLOW))
    else $error("undefined status code");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall |=> !result_valid)
    else $error("second result without an end-of-line beat");

  a_eol_progress: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (kind == KIND_EOL) |=> result_valid || item_stall)
    else $error("end-of-line beat neither answered nor being unwound");

endmodule

bind bracket_nesting_checker_unit bnc_checker u_bnc_checker (.*);

FILE: tb/sv/tb_top.sv
// Testbench for bracket_nesting_checker_unit: random and directed text lines, a line-level
// predictor of status, completion score and open depth, and a scoreboard class.
// Depends on bnc_pkg and the bracket_nesting_checker_unit RTL.
module tb_top
  import bnc_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TARGET_BEATS = 550;

  typedef struct {
    logic [1:0]               status;
    logic [SCORE_W-1:0]       score;
    logic [DEPTH_FIELD_W-1:0] depth;
  } line_result_t;

  class bracket_line_board;
    logic [2:0]   opener_stack [STACK_DEPTH_DEF];
    int           stack_fill;
    bit           corrupt_seen;
    bit           overflow_seen;
    line_result_t expected_lines [$];
    int           mismatches;

    function new();
      stack_fill = 0;
      corrupt_seen = 1'b0;
      overflow_seen = 1'b0;
      mismatches = 0;
    endfunction

    function void decode(input logic [7:0] b, output bit closing, output logic [2:0] code);
      closing = 1'b0;
      code = OP_OTHER;
      case (b)
        CH_LPAREN:  code = OP_PAREN;
        CH_LSQUARE: code = OP_SQUARE;
        CH_LCURLY:  code = OP_CURLY;
        CH_LANGLE:  code = OP_ANGLE;
        CH_RPAREN: begin
          closing = 1'b1;
          code = OP_PAREN;
        end
        CH_RSQUARE: begin
          closing = 1'b1;
          code = OP_SQUARE;
        end
        CH_RCURLY: begin
          closing = 1'b1;
          code = OP_CURLY;
        end
        CH_RANGLE: begin
          closing = 1'b1;
          code = OP_ANGLE;
        end
        default: code = OP_OTHER;
      endcase
    endfunction

    function line_result_t close_line();
      line_result_t r;
      logic [63:0]  acc;
      logic [63:0]  cap;
      int           i;
      cap = {1'b0, SCORE_MAX};
      acc = '0;
      if (corrupt_seen) begin
        r.status = STAT_CORRUPT;
      end else if (overflow_seen) begin
        r.status = STAT_OVERFLOW;
      end else begin
        r.status = STAT_OK;
        for (i = stack_fill - 1; i >= 0; i--) begin
          if (acc > (cap - 64'(opener_stack[i])) / 64'd5)
            acc = cap;
          else
            acc = acc * 64'd5 + 64'(opener_stack[i]);
        end
      end
      r.score = acc[SCORE_W-1:0];
      r.depth = (stack_fill > DEPTH_FIELD_MAX) ? DEPTH_FIELD_W'(DEPTH_FIELD_MAX)
                                               : DEPTH_FIELD_W'(stack_fill);
      stack_fill = 0;
      corrupt_seen = 1'b0;
      overflow_seen = 1'b0;
      return r;
    endfunction

    // Returns 1 when the beat has an effect, 0 when the line is already dead.
    function bit note_item(input logic k, input logic [7:0] b);
      bit         closing;
      logic [2:0] code;
      if (k == KIND_EOL) begin
        expected_lines.insert(expected_lines.size(), close_line());
        return 1'b1;
      end
      if (corrupt_seen || overflow_seen) return 1'b0;
      decode(b, closing, code);
      if (closing) begin
        if (stack_fill == 0 || opener_stack[stack_fill-1] != code)
          corrupt_seen = 1'b1;
        else
          stack_fill--;
      end else if (stack_fill >= STACK_DEPTH_DEF) begin
        overflow_seen = 1'b1;
      end else begin
        opener_stack[stack_fill] = code;
        stack_fill++;
      end
      return 1'b1;
    endfunction

    function void check_result(input logic [1:0] st, input logic [SCORE_W-1:0] sc,
                               input logic [DEPTH_FIELD_W-1:0] dp);
      line_result_t want;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d score %0d depth %0d", st, sc, dp);
        return;
      end
      want = expected_lines.pop_front();
      if (st !== want.status || sc !== want.score || dp !== want.depth) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: status %0d/%0d score %0d/%0d depth %0d/%0d (exp/act)",
                   want.status, st, want.score, sc, want.depth, dp);
      end
    endfunction

    function int waiting();
      return expected_lines.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic                     kind = KIND_CHAR;
  logic [7:0]               symbol = 8'h00;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [1:0]               status;
  logic [SCORE_W-1:0]       completion_score;
  logic [DEPTH_FIELD_W-1:0] open_depth;

  bracket_line_board board;
  logic [7:0]        line_buf [$];
  logic [7:0]        opener_ch [1:4] = '{CH_LPAREN, CH_LSQUARE, CH_LCURLY, CH_LANGLE};
  logic [7:0]        closer_ch [1:4] = '{CH_RPAREN, CH_RSQUARE, CH_RCURLY, CH_RANGLE};
  int                beats_used = 0;
  int                cycle_count = 0;
  int                hold = 0;
  bit                send_calm = 1'b0;
  bit                take_calm = 1'b0;

  bracket_nesting_checker_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .symbol(symbol),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .completion_score(completion_score),
    .open_depth(open_depth)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      board.check_result(status, completion_score, open_depth);
      if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
      hold = take_calm ? 0 : $urandom_range(0, 4);
      result_stall <= (hold != 0);
    end else if (!rst && result_valid && result_stall) begin
      hold = hold - 1;
      if (hold <= 0) result_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b == CH_RPAREN || b == CH_RSQUARE || b == CH_RCURLY || b == CH_RANGLE);
    return b;
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    symbol <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    void'(board.note_item(k, b));
    beats_used++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_item(KIND_CHAR, line_buf[i]);
    send_item(KIND_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_line();
    int         pick;
    int         len;
    int         pop_pct;
    int         code;
    int         n;
    logic [2:0] codes [$];
    line_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 83) begin
      len = $urandom_range(0, 12);
      for (n = 0; n < len; n++) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 65) begin
      len = $urandom_range(0, 20);
      pop_pct = 40;
    end else if (pick < 75) begin
      len = ($urandom_range(0, 3) == 0) ? STACK_DEPTH_DEF : $urandom_range(20, STACK_DEPTH_DEF - 1);
      pop_pct = 0;
    end else begin
      len = STACK_DEPTH_DEF + $urandom_range(1, 3);
      pop_pct = 0;
    end
    for (n = 0; n < len; n++) begin
      if (pop_pct > 0 && codes.size() > 0 && codes[$] != OP_OTHER &&
          $urandom_range(0, 99) < pop_pct) begin
        append_byte(closer_ch[codes[$]]);
        void'(codes.pop_back());
      end else if ($urandom_range(0, 4) == 0) begin
        append_byte(plain_byte());
        codes.insert(codes.size(), OP_OTHER);
      end else begin
        code = $urandom_range(OP_PAREN, OP_ANGLE);
        append_byte(opener_ch[code]);
        codes.insert(codes.size(), code[2:0]);
      end
    end
    if (pick >= 50 && pick < 65) begin
      do
        code = $urandom_range(OP_PAREN, OP_ANGLE);
      while (codes.size() > 0 && codes[$] == code[2:0]);
      append_byte(closer_ch[code]);
    end
    if (pick >= 50) begin
      len = $urandom_range(0, 5);
      for (n = 0; n < len; n++) append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    line_buf.delete();
    send_line();
    line_buf = '{CH_LPAREN, CH_LSQUARE, CH_LCURLY, CH_LANGLE};
    send_line();
    line_buf = '{8'h00, 8'hFF};
    send_line();
    line_buf = '{CH_LPAREN, CH_RPAREN, CH_LSQUARE, CH_RSQUARE,
                 CH_LCURLY, CH_RCURLY, CH_LANGLE, CH_RANGLE};
    send_line();
    line_buf = '{CH_RPAREN};
    send_line();
    line_buf = '{CH_LPAREN, CH_RSQUARE, CH_RPAREN};
    send_line();

    while (beats_used < TARGET_BEATS) begin
      random_line();
      send_line();
    end
    item_valid <= 1'b0;

    while (board.waiting() != 0) @(posedge clk);
    repeat (STACK_DEPTH_DEF + 16) @(posedge clk);
    if (board.mismatches == 0 && board.waiting() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
